FILE: design/pwws_pkg.sv
// Shared constants and control types for the pixel widening and Welford statistics block.
package pwws_pkg;

	// Field widths
	localparam int PIX_W      = 12;
	localparam int WIDE_W     = 16;
	localparam int WIDE_SHIFT = WIDE_W - PIX_W;
	localparam int MEAN_OUT_W = 28;
	localparam int SQ_W       = 60;
	localparam int CNT_W      = 23;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = WIDE_W + MEAN_OUT_W + SQ_W;

	// Defaults for the top-level parameters and the frame length register
	localparam int MAX_FRAME_PIXELS_DEF = 4194304;
	localparam int FRAC_BITS_DEF        = 16;
	localparam logic [CNT_W-1:0] FRAME_PIXELS_RST = CNT_W'(1048576);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take a pixel, form delta, count and frame end
		logic div_step; // one quotient bit of delta / count
		logic mean;     // form the new mean
		logic dev;      // form the second deviation
		logic mul;      // multiply the deviation magnitudes
		logic finish;   // update statistics and load the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_busy; // output register holds a result not yet taken
	} status_t;

endpackage

FILE: design/pwws_ctrl.sv
// Controller state machine that sequences one pixel through the statistics datapath.
module pwws_ctrl import pwws_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam int MEAN_W = PIX_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(MEAN_W);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(MEAN_W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MEAN = 3'd2;
	localparam logic [2:0] ST_DEV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [DCNT_W-1:0] div_cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	// Decode commands and next state
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) state_d = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.mean = 1'b1;
				state_d  = ST_DEV;
			end
			ST_DEV: begin
				cmd.dev = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!st.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_cnt_q <= DIV_LAST;
			end else if (cmd.div_step && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !st.out_busy) |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after finishing");

endmodule

FILE: design/pwws_dp.sv
// Datapath: delta, radix-2 divider, mean and M2 update, output register.
module pwws_dp import pwws_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF,
	parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  cfg_wr_en,
	input  logic [CNT_W-1:0]      cfg_wr_data,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int MEAN_W = PIX_W + FRAC_BITS;
	localparam int PROD_W = 2 * MEAN_W;
	localparam int INC_W  = PROD_W - FRAC_BITS;
	localparam logic [CNT_W+1:0] MAX_N = (CNT_W + 2)'(MAX_FRAME_PIXELS);
	localparam logic [MEAN_W-1:0] MEAN_MAX = {{PIX_W{1'b1}}, {FRAC_BITS{1'b0}}};

	logic [CNT_W-1:0]      frame_pixels_q;
	logic [CNT_W-1:0]      count_q;
	logic [MEAN_W-1:0]     mean_acc_q;
	logic [SQ_W-1:0]       sq_acc_q;

	logic [PIX_W-1:0]      pixel_q;
	logic                  neg_q;
	logic                  last_q;
	logic [CNT_W-1:0]      n_q;
	logic [MEAN_W-1:0]     dmag_q;
	logic [MEAN_W-1:0]     div_q;
	logic [CNT_W-1:0]      rem_q;
	logic [MEAN_W-1:0]     new_mean_q;
	logic [MEAN_W-1:0]     dev2_q;
	logic [PROD_W-1:0]     prod_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	logic [PIX_W-1:0]      pixel_in;
	logic [MEAN_W-1:0]     v_in;
	logic [MEAN_W-1:0]     v_cur;
	logic [CNT_W-1:0]      n_in;
	logic                  neg_in;
	logic [CNT_W:0]        trial;
	logic                  trial_ge;
	logic [INC_W-1:0]      inc;
	logic [SQ_W:0]         sq_sum;
	logic [SQ_W-1:0]       sq_next;

	assign pixel_in = s_tdata[PIX_W-1:0];
	assign v_in     = {pixel_in, {FRAC_BITS{1'b0}}};
	assign v_cur    = {pixel_q, {FRAC_BITS{1'b0}}};
	assign n_in     = count_q + 1'b1;
	assign neg_in   = v_in < mean_acc_q;

	// One restoring division step
	assign trial    = {rem_q, div_q[MEAN_W-1]};
	assign trial_ge = trial >= {1'b0, n_q};

	// Saturating M2 accumulation
	assign inc     = prod_q[PROD_W-1:FRAC_BITS];
	assign sq_sum  = {1'b0, sq_acc_q} + (SQ_W + 1)'(inc);
	assign sq_next = sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];

	assign st.out_busy = out_valid_q && !m_tready;
	assign m_tvalid    = out_valid_q;
	assign m_tdata     = out_data_q;
	assign m_tlast     = out_last_q;

	// Frame length register and per-frame statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
			count_q        <= '0;
			mean_acc_q     <= '0;
			sq_acc_q       <= '0;
		end else begin
			if (cfg_wr_en) frame_pixels_q <= cfg_wr_data;
			if (cmd.finish) begin
				if (last_q) begin
					count_q    <= '0;
					mean_acc_q <= '0;
					sq_acc_q   <= '0;
				end else begin
					count_q    <= n_q;
					mean_acc_q <= new_mean_q;
					sq_acc_q   <= sq_next;
				end
			end
		end
	end

	// Output transaction valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current pixel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_q <= pixel_in;
			neg_q   <= neg_in;
			n_q     <= n_in;
			last_q  <= (n_in >= frame_pixels_q) || ({2'b00, n_in} >= MAX_N);
			dmag_q  <= neg_in ? (mean_acc_q - v_in) : (v_in - mean_acc_q);
			div_q   <= neg_in ? (mean_acc_q - v_in) : (v_in - mean_acc_q);
			rem_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];
			div_q <= {div_q[MEAN_W-2:0], trial_ge};
		end
		if (cmd.mean) begin
			new_mean_q <= neg_q ? (mean_acc_q - div_q) : (mean_acc_q + div_q);
		end
		if (cmd.dev) begin
			dev2_q <= (v_cur >= new_mean_q) ? (v_cur - new_mean_q) : (new_mean_q - v_cur);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(dmag_q) * PROD_W'(dev2_q);
		end
		if (cmd.finish) begin
			out_data_q <= {sq_next, MEAN_OUT_W'(new_mean_q),
				{pixel_q, {WIDE_SHIFT{1'b0}}}};
			out_last_q <= last_q;
		end
	end

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result appeared without a finished pixel");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mean_acc_q <= MEAN_MAX)
		else $error("running mean left the pixel range");

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && last_q) |=> (count_q == '0 && sq_acc_q == '0))
		else $error("statistics not cleared at frame end");

endmodule

FILE: design/pixel_widen_welford_stats.sv
// Top level of the pixel widening and per-frame Welford statistics block.
//
// Each accepted pixel is processed before the next one is taken: the radix-2 divider that
// forms delta / count yields one quotient bit per cycle, and the mean, deviation, multiply
// and update steps follow it. The result sits in an output register, so the next pixel is
// taken while it waits; a pixel finishes only once the previous result has been taken.
// m_tlast marks the last pixel of a frame, whose transaction carries the final mean and
// M2 (undivided).
module pixel_widen_welford_stats import pwws_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF,
	parameter int FRAC_BITS        = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,     // [11:0] pixel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,     // [15:0] wide_pixel, [43:16] frame_mean,
	                                           // [103:44] frame_sq_dev_sum
	output logic                  m_tlast,     // frame_end
	input  logic                  cfg_wr_en,
	input  logic [CNT_W-1:0]      cfg_wr_data  // frame_pixels
);

	cmd_t    cmd;
	status_t st;

	pwws_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	pwws_dp #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
		.FRAC_BITS        (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
